// File: rtl/cmig_pkg.sv
// Package for the chaotic map index generator: widths, register indexes,
// fixed-point constants. No dependencies.
`timescale 1ns / 1ps
package cmig_pkg;
  localparam int unsigned MaxDim   = 4096;
  localparam int unsigned FracBits = 32;
  localparam int unsigned CfgW     = 32;
  localparam int unsigned CntW     = 13;
  localparam int unsigned IdxW     = 12;

  localparam logic [2:0] RegRate   = 3'd0;
  localparam logic [2:0] RegSeedX  = 3'd1;
  localparam logic [2:0] RegSeedY  = 3'd2;
  localparam logic [2:0] RegWarmup = 3'd3;
  localparam logic [2:0] RegMod    = 3'd4;
  localparam logic [2:0] RegLen    = 3'd5;

  localparam logic [31:0] Billion = 32'd1000000000;
endpackage

// File: rtl/cmig_qmul.sv
// Bit-serial fixed-point multiplier: floor(a*b / 2^F) with saturation.
// One multiplier bit per cycle, shift-add. Uses cmig_pkg.
`timescale 1ns / 1ps
module cmig_qmul #(
  parameter int unsigned FracBits = cmig_pkg::FracBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [FracBits+2:0]   a_i,
  input  logic [FracBits+2:0]   b_i,
  output logic                  done_o,
  output logic [FracBits+2:0]   p_o
);
  localparam int unsigned OpW  = FracBits + 3;
  localparam int unsigned AccW = 2 * OpW;
  localparam int unsigned CntW = $clog2(OpW + 1);

  logic [AccW-1:0] acc_q, acc_d;
  logic [OpW-1:0]  mcand_q, mcand_d, mplier_q, mplier_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [OpW:0]    upper;

  // One shift-add step per cycle, least significant multiplier bit first.
  always_comb begin
    acc_d = acc_q; mcand_d = mcand_q; mplier_d = mplier_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    upper = {1'b0, acc_q[AccW-1:OpW]} + (mplier_q[0] ? {1'b0, mcand_q} : '0);
    if (start_i) begin
      acc_d = '0; mcand_d = a_i; mplier_d = b_i;
      cnt_d = CntW'(OpW); busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d    = {upper, acc_q[OpW-1:1]};
      mplier_d = mplier_q >> 1;
      cnt_d    = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; mcand_q <= mcand_d; mplier_q <= mplier_d;
  end

  // Saturate when the shifted product exceeds the operand width.
  assign done_o = done_q;
  assign p_o = (|acc_q[AccW-1:FracBits+OpW]) ? '1 : acc_q[FracBits +: OpW];
endmodule

// File: rtl/cmig_mod.sv
// Bit-serial restoring remainder of a wide value by a 13-bit modulus.
// One dividend bit per cycle. Uses cmig_pkg.
`timescale 1ns / 1ps
module cmig_mod #(
  parameter int unsigned NumW = cmig_pkg::FracBits + 3
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [NumW-1:0]           num_i,
  input  logic [cmig_pkg::CntW-1:0] den_i,
  output logic                      done_o,
  output logic [cmig_pkg::IdxW-1:0] rem_o
);
  localparam int unsigned RW = cmig_pkg::CntW + 1;
  localparam int unsigned CW = $clog2(NumW + 1);

  logic [NumW-1:0] num_q, num_d;
  logic [RW-1:0]   rem_q, rem_d, trial;
  logic [cmig_pkg::CntW-1:0] den_q, den_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;

  // Shift one dividend bit into the partial remainder and subtract if it fits.
  always_comb begin
    num_d = num_q; rem_d = rem_q; den_d = den_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q[RW-2:0], num_q[NumW-1]};
    if (start_i) begin
      num_d = num_i; rem_d = '0; cnt_d = CW'(NumW); busy_d = 1'b1;
      den_d = (den_i > cmig_pkg::CntW'(4096)) ? cmig_pkg::CntW'(4096) : den_i;
    end else if (busy_q) begin
      num_d = num_q << 1;
      rem_d = (trial >= {1'b0, den_q}) ? trial - {1'b0, den_q} : trial;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; rem_q <= rem_d; den_q <= den_d;
  end

  // A zero modulus gives zero.
  assign done_o = done_q;
  assign rem_o  = (den_q == '0) ? '0 : rem_q[cmig_pkg::IdxW-1:0];
endmodule

// File: rtl/chaotic_map_index_generator.sv
// Chaotic map index generator: coupled 2D logistic map in fixed point.
// Depends on cmig_pkg, cmig_qmul and cmig_mod.
// Each request runs 7 multiplies on the shared multiplier and one modulo; a restart,
// or the first request after reset, adds warmup_count*6 multiplies.
// One request at a time: a new one is taken only after the result is accepted.
// Reset restores defaults.
`timescale 1ns / 1ps
module chaotic_map_index_generator #(
  parameter int unsigned FracBits = cmig_pkg::FracBits
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [2:0]                cfg_index_i,
  input  logic [cmig_pkg::CfgW-1:0] cfg_data_i,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic                      restart_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic [cmig_pkg::IdxW-1:0] index_value_o,
  output logic                      last_o
);
  localparam int unsigned OpW = FracBits + 3;
  localparam logic [OpW-1:0] One = OpW'(1) << FracBits;

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StMul1  = 7'b0000010,
    StMul2  = 7'b0000100,
    StMul3  = 7'b0001000,
    StScale = 7'b0010000,
    StMod   = 7'b0100000,
    StOut   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [30:0] rate_q;
  logic [31:0] seedx_q, seedy_q;
  logic [5:0]  warm_q, wleft_q, wleft_d;
  logic [cmig_pkg::CntW-1:0] mod_q, len_q, cnt_q, cnt_d, next_cnt;
  logic [FracBits-1:0] x_q, x_d, y_q, y_d;
  logic primed_q, primed_d, ysel_q, ysel_d, last_q, last_d;
  logic [OpW-1:0] prod_q, prod_d, a_op, b_op, mul_p, rate_al, cur, oth;
  logic [FracBits-1:0] sat;
  logic mul_go_q, mul_go_d, mod_go_q, mod_go_d, mul_done, mod_done;
  logic [cmig_pkg::IdxW-1:0] rem;

  // Align Q0.32 seeds and Q1.30 rate to F fraction bits.
  function automatic logic [FracBits-1:0] al32(input logic [31:0] v);
    logic [FracBits+31:0] w;
    w = {v, FracBits'(0)};
    return w[FracBits+31 -: FracBits];
  endfunction
  assign rate_al = OpW'({rate_q, FracBits'(0)} >> 30);

  // Unit start pulses are registered, so they arrive in the same cycle as the new state, once the operands are settled.
  cmig_qmul #(.FracBits(FracBits)) u_mul (
    .clk_i, .rst_ni, .start_i(mul_go_q), .a_i(a_op), .b_i(b_op),
    .done_o(mul_done), .p_o(mul_p)
  );
  cmig_mod #(.NumW(OpW)) u_mod (
    .clk_i, .rst_ni, .start_i(mod_go_q), .num_i(prod_q), .den_i(mod_q),
    .done_o(mod_done), .rem_o(rem)
  );

  // Coordinate being updated and its partner.
  assign cur = ysel_q ? OpW'(y_q) : OpW'(x_q);
  assign oth = ysel_q ? OpW'(x_q) : OpW'(y_q);
  assign sat = (mul_p >= One) ? '1 : mul_p[FracBits-1:0];
  assign next_cnt = cnt_q + 1'b1;

  // Operand selection for the shared multiplier.
  always_comb begin
    case (state_q)
      StMul1:  begin a_op = rate_al; b_op = OpW'(3) * oth + One; end
      StMul2:  begin a_op = prod_q;  b_op = cur; end
      StMul3:  begin a_op = prod_q;  b_op = One - cur; end
      StScale: begin a_op = OpW'(x_q); b_op = OpW'(cmig_pkg::Billion); end
      default: begin a_op = '0; b_op = '0; end
    endcase
  end

  // Sequencer: restart load, warm-up steps, request step, scale, modulo.
  always_comb begin
    state_d = state_q; x_d = x_q; y_d = y_q; wleft_d = wleft_q;
    primed_d = primed_q; ysel_d = ysel_q; prod_d = prod_q;
    cnt_d = cnt_q; last_d = last_q; mul_go_d = 1'b0; mod_go_d = 1'b0;
    case (state_q)
      StIdle: begin
        if (valid_i) begin
          if (restart_i || !primed_q) begin
            x_d = al32(seedx_q); y_d = al32(seedy_q);
            wleft_d = warm_q; primed_d = 1'b1; cnt_d = '0;
          end else begin
            wleft_d = '0;
          end
          ysel_d = 1'b0; mul_go_d = 1'b1; state_d = StMul1;
        end
      end
      StMul1: if (mul_done) begin
        prod_d = mul_p; mul_go_d = 1'b1; state_d = StMul2;
      end
      StMul2: if (mul_done) begin
        prod_d = mul_p; mul_go_d = 1'b1; state_d = StMul3;
      end
      StMul3: if (mul_done) begin
        if (ysel_q) y_d = sat; else x_d = sat;
        ysel_d = ~ysel_q; mul_go_d = 1'b1;
        if (!ysel_q) state_d = StMul1;
        else if (wleft_q != '0) begin
          wleft_d = wleft_q - 1'b1; state_d = StMul1;
        end else state_d = StScale;
      end
      StScale: if (mul_done) begin
        prod_d = mul_p; mod_go_d = 1'b1; state_d = StMod;
      end
      StMod: if (mod_done) begin
        last_d = (next_cnt == len_q);
        cnt_d = last_d ? '0 : next_cnt;
        state_d = StOut;
      end
      StOut: if (ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; x_q <= '0; y_q <= '0; primed_q <= 1'b0;
      cnt_q <= '0; wleft_q <= '0; ysel_q <= 1'b0; last_q <= 1'b0;
      mul_go_q <= 1'b0; mod_go_q <= 1'b0;
      rate_q <= 31'd1234803098; seedx_q <= 32'h8000_0000;
      seedy_q <= 32'h8000_0000; warm_q <= 6'd10;
      mod_q <= 13'd4096; len_q <= 13'd4096;
    end else begin
      state_q <= state_d; x_q <= x_d; y_q <= y_d; primed_q <= primed_d;
      cnt_q <= cnt_d; wleft_q <= wleft_d; ysel_q <= ysel_d; last_q <= last_d;
      mul_go_q <= mul_go_d; mod_go_q <= mod_go_d;
      // Configuration writes.
      if (cfg_we_i) begin
        case (cfg_index_i)
          cmig_pkg::RegRate:   rate_q  <= cfg_data_i[30:0];
          cmig_pkg::RegSeedX:  seedx_q <= cfg_data_i;
          cmig_pkg::RegSeedY:  seedy_q <= cfg_data_i;
          cmig_pkg::RegWarmup: warm_q  <= cfg_data_i[5:0];
          cmig_pkg::RegMod:    mod_q   <= cfg_data_i[12:0];
          cmig_pkg::RegLen:    len_q   <= cfg_data_i[12:0];
          default: ;
        endcase
      end
    end
  end

  // Result register, held in the output state.
  logic [cmig_pkg::IdxW-1:0] idx_q;
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (state_q == StMod && mod_done) idx_q <= rem;
  end

  assign ready_o       = (state_q == StIdle);
  assign valid_o       = (state_q == StOut);
  assign index_value_o = idx_q;
  assign last_o        = last_q;
endmodule
